// File: sv/polynomial_multiply_assert.svh
// ----------------------------------------------------------------------------
// polynomial_multiply_assert.svh
// Assertion macros for the polynomial multiplier. Define ASSERT_OFF to drop.
// ----------------------------------------------------------------------------
`ifndef POLYNOMIAL_MULTIPLY_ASSERT_SVH
`define POLYNOMIAL_MULTIPLY_ASSERT_SVH

`ifndef ASSERT_OFF
// Checked outside of reset.
`define PM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked at every edge, reset included.
`define PM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PM_ASSERT(lbl, prop, msg)
`define PM_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// File: sv/pm_pkg.sv
// ----------------------------------------------------------------------------
// pm_pkg
// Shared constants, command and status types of the polynomial multiplier.
// ----------------------------------------------------------------------------
package pm_pkg;

  localparam int MAX_DEGREE  = 31;
  localparam int COEF_SLOTS  = MAX_DEGREE + 1;
  localparam int PROD_SLOTS  = 2 * MAX_DEGREE + 1;
  localparam int COEF_W      = 32;
  localparam int ADDR_W      = $clog2(COEF_SLOTS);      // store address / degree
  localparam int IDX_W       = $clog2(COEF_SLOTS + 1);  // load index, saturates at slots
  localparam int K_W         = $clog2(PROD_SLOTS);      // product coefficient index
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  typedef logic [COEF_W-1:0] coef_t;
  typedef logic [ADDR_W-1:0] addr_t;

  // One command from the front end to the back end.
  typedef struct packed {
    logic  wr_en;   // store data at addr
    logic  wr_b;    // 0: store A, 1: store B
    addr_t addr;
    coef_t data;
    logic  prod;    // run the product after the write
    addr_t deg_a;
    addr_t deg_b;
    logic  drop;    // coefficients were dropped since the last product
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_NEXT,
    B_ISSUE
  } back_state_t;

endpackage

// File: sv/pm_front.sv
// ----------------------------------------------------------------------------
// pm_front
// Accepts coefficient items, tracks load indexes and degrees, emits commands.
// ----------------------------------------------------------------------------
module pm_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [pm_pkg::COEF_W-1:0]   in_tdata,
  input  logic                        in_tuser,
  input  logic                        in_tlast,
  input  pm_pkg::q_stat_t             q_stat,
  output logic                        q_push,
  output pm_pkg::cmd_t                q_cmd
);
  import pm_pkg::*;

  logic [IDX_W-1:0] idx_a_r, idx_a_nxt;
  logic [IDX_W-1:0] idx_b_r, idx_b_nxt;
  addr_t            deg_a_r, deg_a_nxt;
  logic             drop_r, drop_nxt;

  logic             accept;
  logic [IDX_W-1:0] idx;
  logic             fits;
  logic [IDX_W-1:0] idx_inc;
  logic [IDX_W-1:0] idx_m1;
  addr_t            deg_new;
  logic             do_prod;

  assign in_tready = !q_stat.full;
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    idx     = in_tuser ? idx_b_r : idx_a_r;
    fits    = (idx <= IDX_W'(MAX_DEGREE));
    idx_inc = fits ? idx + IDX_W'(1) : idx;
    idx_m1  = idx_inc - IDX_W'(1);
    deg_new = (idx_m1 > IDX_W'(MAX_DEGREE)) ? ADDR_W'(MAX_DEGREE) : idx_m1[ADDR_W-1:0];
    do_prod = in_tuser && in_tlast;
  end

  always_comb begin
    q_cmd.wr_en = fits;
    q_cmd.wr_b  = in_tuser;
    q_cmd.addr  = idx[ADDR_W-1:0];
    q_cmd.data  = in_tdata;
    q_cmd.prod  = do_prod;
    q_cmd.deg_a = deg_a_r;        // B completes: A's degree as it stands
    q_cmd.deg_b = deg_new;
    q_cmd.drop  = drop_r || !fits;
    q_push      = accept && (fits || do_prod);
  end

  always_comb begin
    idx_a_nxt = idx_a_r;
    idx_b_nxt = idx_b_r;
    deg_a_nxt = deg_a_r;
    drop_nxt  = drop_r;
    if (accept) begin
      if (!in_tuser) begin
        idx_a_nxt = in_tlast ? '0 : idx_inc;
        if (in_tlast) begin
          deg_a_nxt = deg_new;
        end
      end else begin
        idx_b_nxt = in_tlast ? '0 : idx_inc;
      end
      if (do_prod) begin
        drop_nxt = 1'b0;
      end else if (!fits) begin
        drop_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_a_r <= '0;
      idx_b_r <= '0;
      deg_a_r <= '0;
      drop_r  <= 1'b0;
    end else begin
      idx_a_r <= idx_a_nxt;
      idx_b_r <= idx_b_nxt;
      deg_a_r <= deg_a_nxt;
      drop_r  <= drop_nxt;
    end
  end

endmodule

// File: sv/pm_queue.sv
// ----------------------------------------------------------------------------
// pm_queue
// Short command queue between front end and back end.
// ----------------------------------------------------------------------------
module pm_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  pm_pkg::cmd_t    push_cmd,
  input  logic            pop,
  output pm_pkg::cmd_t    head_cmd,
  output pm_pkg::q_stat_t stat
);
  import pm_pkg::*;

  cmd_t                q_mem [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QUEUE_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QUEUE_CW-1:0] cnt_r, cnt_nxt;
  logic                do_push;
  logic                do_pop;

  assign stat.empty = (cnt_r == '0);
  assign stat.full  = (cnt_r == QUEUE_CW'(QUEUE_DEPTH));
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head_cmd   = q_mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + QUEUE_AW'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + QUEUE_AW'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + QUEUE_CW'(1);
    end else if (!do_push && do_pop) begin
      cnt_nxt = cnt_r - QUEUE_CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_mem[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

// File: sv/pm_back.sv
// ----------------------------------------------------------------------------
// pm_back
// Coefficient stores and multiply-accumulate sequencer producing the product.
// ----------------------------------------------------------------------------
module pm_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  pm_pkg::q_stat_t             q_stat,
  input  pm_pkg::cmd_t                q_cmd,
  output logic                        q_pop,
  output logic                        back_busy,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [pm_pkg::COEF_W-1:0]   out_tdata,
  output logic                        out_tlast,
  output logic                        out_tuser
);
  import pm_pkg::*;

  back_state_t state_r, state_nxt;

  // coefficient stores
  coef_t                 store_a_mem [COEF_SLOTS];
  coef_t                 store_b_mem [COEF_SLOTS];
  logic [COEF_SLOTS-1:0] a_valid_r;

  // current product
  addr_t          da_r, db_r;
  logic           drop_r;
  logic [K_W-1:0] k_r;
  addr_t          i_r;

  // read stage
  logic  v1_r;
  coef_t a_rd_r, b_rd_r;
  logic  a_ok_r;
  logic  first1_r, last1_r, fin1_r, drop1_r;

  // multiply stage
  logic  v2_r;
  coef_t p2_r;
  logic  first2_r, last2_r, fin2_r, drop2_r;

  coef_t acc_r;
  logic  out_valid_r, out_valid_nxt;
  coef_t out_data_r;
  logic  out_last_r, out_drop_r;

  logic [K_W-1:0]      da_k, db_k, n_m1, lo_k, hi_k, j_k;
  addr_t               lo, hi, b_addr;
  logic                wr_a, wr_b, latch, start_ok, start, issue;
  logic                term_end, prod_end;
  coef_t               a_eff, sum;
  logic [2*COEF_W-1:0] mul_full;

  // term range of output k: i in [max(0, k-db), min(k, da)], j = k - i
  always_comb begin
    da_k     = K_W'(da_r);
    db_k     = K_W'(db_r);
    n_m1     = da_k + db_k;
    lo_k     = (k_r > db_k) ? k_r - db_k : '0;
    hi_k     = (k_r < da_k) ? k_r : da_k;
    lo       = lo_k[ADDR_W-1:0];
    hi       = hi_k[ADDR_W-1:0];
    j_k      = k_r - K_W'(i_r);
    b_addr   = j_k[ADDR_W-1:0];
    term_end = (i_r == hi);
    prod_end = (k_r == n_m1);
    // next output may start once the pipe is empty and the output slot frees
    start_ok = !v1_r && !v2_r && (!out_valid_r || out_tready);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      B_IDLE: begin
        if (!q_stat.empty && q_cmd.prod) begin
          state_nxt = B_NEXT;
        end
      end
      B_NEXT: begin
        if (start_ok) begin
          state_nxt = B_ISSUE;
        end
      end
      B_ISSUE: begin
        if (term_end) begin
          state_nxt = prod_end ? B_IDLE : B_NEXT;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_comb begin
    q_pop = 1'b0;
    wr_a  = 1'b0;
    wr_b  = 1'b0;
    latch = 1'b0;
    start = 1'b0;
    issue = 1'b0;
    case (state_r)
      B_IDLE: begin
        if (!q_stat.empty) begin
          q_pop = 1'b1;
          wr_a  = q_cmd.wr_en && !q_cmd.wr_b;
          wr_b  = q_cmd.wr_en && q_cmd.wr_b;
          latch = q_cmd.prod;
        end
      end
      B_NEXT:  start = start_ok;
      B_ISSUE: issue = 1'b1;
      default: begin
      end
    endcase
  end

  assign back_busy = (state_r != B_IDLE);

  // stores: one write port, one registered read port each
  always_ff @(posedge clk) begin
    if (wr_a) begin
      store_a_mem[q_cmd.addr] <= q_cmd.data;
    end
    if (issue) begin
      a_rd_r <= store_a_mem[i_r];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_b) begin
      store_b_mem[q_cmd.addr] <= q_cmd.data;
    end
    if (issue) begin
      b_rd_r <= store_b_mem[b_addr];
    end
  end

  // A entries never written read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= '0;
    end else if (wr_a) begin
      a_valid_r[q_cmd.addr] <= 1'b1;
    end
  end

  always_comb begin
    a_eff    = a_ok_r ? a_rd_r : '0;
    mul_full = a_eff * b_rd_r;
    sum      = (first2_r ? '0 : acc_r) + p2_r;
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (v2_r && last2_r) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // sequencing and datapath payload
  always_ff @(posedge clk) begin
    if (latch) begin
      da_r   <= q_cmd.deg_a;
      db_r   <= q_cmd.deg_b;
      drop_r <= q_cmd.drop;
      k_r    <= '0;
    end else if (issue && term_end && !prod_end) begin
      k_r <= k_r + K_W'(1);
    end
    if (start) begin
      i_r <= lo;
    end else if (issue) begin
      i_r <= i_r + ADDR_W'(1);
    end
    if (issue) begin
      a_ok_r   <= a_valid_r[i_r];
      first1_r <= (i_r == lo);
      last1_r  <= term_end;
      fin1_r   <= term_end && prod_end;
      drop1_r  <= drop_r;
    end
    p2_r     <= mul_full[COEF_W-1:0];
    first2_r <= first1_r;
    last2_r  <= last1_r;
    fin2_r   <= fin1_r;
    drop2_r  <= drop1_r;
    if (v2_r && !last2_r) begin
      acc_r <= sum;
    end
    if (v2_r && last2_r) begin
      out_data_r <= sum;
      out_last_r <= fin2_r;
      out_drop_r <= drop2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      v1_r        <= issue;
      v2_r        <= v1_r;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_drop_r;

endmodule

// File: sv/polynomial_multiply.sv
// ----------------------------------------------------------------------------
// polynomial_multiply
// Integer polynomial multiplier (full convolution), streaming in and out.
// ----------------------------------------------------------------------------
// Coefficients of A (in_tuser = 0) and B (in_tuser = 1) stream in lowest power
// first, in_tlast on the highest one; up to 32 are kept per polynomial, extras
// are dropped and reported on out_tuser of the next product. The item that
// ends B starts the product: degree_a+degree_b+1 coefficients stream out
// lowest power first, out_tlast on the last, all arithmetic wrapped to 32 bits.
// A is the zero polynomial until first loaded. Loading takes one cycle per
// item while the command queue has room. Product coefficients are worked out
// one after another on the single 32x32 multiplier fed from one read port of
// each store; the read and multiply stages drain and the output register must
// be free before the next coefficient starts. A four-entry command queue lets
// loading of the next operands continue while a product runs.
// ----------------------------------------------------------------------------
module polynomial_multiply (
  input  logic                        clk,
  input  logic                        rst_n,
  // input items
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [pm_pkg::COEF_W-1:0]   in_tdata,   // [31:0] coefficient
  input  logic                        in_tuser,   // [0] operand_select (0: A, 1: B)
  input  logic                        in_tlast,   // last_coefficient
  // result items
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [pm_pkg::COEF_W-1:0]   out_tdata,  // [31:0] product_coefficient
  output logic                        out_tuser,  // [0] overflow_dropped
  output logic                        out_tlast   // last_product
);
  import pm_pkg::*;

  q_stat_t q_stat;
  cmd_t    push_cmd;
  cmd_t    head_cmd;
  logic    q_push;
  logic    q_pop;
  logic    back_busy;

  // front end: indexes, degrees and drop tracking
  pm_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .q_stat    (q_stat),
    .q_push    (q_push),
    .q_cmd     (push_cmd)
  );

  // commands: store writes and product starts, in arrival order
  pm_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .pop      (q_pop),
    .head_cmd (head_cmd),
    .stat     (q_stat)
  );

  // back end: stores, MAC pipe, output register
  pm_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_stat     (q_stat),
    .q_cmd      (head_cmd),
    .q_pop      (q_pop),
    .back_busy  (back_busy),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

`include "polynomial_multiply_assert.svh"

  // no result right out of reset
  `PM_ASSERT_ALWAYS(a_reset_quiet, !rst_n |=> !out_tvalid, "result valid after reset")
  // back end only pops a non-empty queue
  `PM_ASSERT(a_pop_nonempty, q_pop |-> !q_stat.empty, "pop from empty queue")
  // the item closing B leaves work pending in the queue or the back end
  `PM_ASSERT(a_prod_pending, (in_tvalid && in_tready && in_tuser && in_tlast) |=> (!q_stat.empty || back_busy), "product command lost")

endmodule

// File: tb/tb_polynomial_multiply.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_polynomial_multiply
// Self-checking bench for the streaming polynomial multiplier.
// ----------------------------------------------------------------------------
// Coefficients of A and B are streamed in. A local model keeps both operand
// stores and works out the full convolution whenever B completes. Every product
// coefficient that comes out is checked against the oldest expected one:
// value, last mark and drop flag. Both sides idle at random. One test holds off
// the receiver long enough to back up the command queue.
// ----------------------------------------------------------------------------
module tb_polynomial_multiply;
  import pm_pkg::*;

  // operand select codes carried on in_tuser
  localparam logic SEL_A = 1'b0;
  localparam logic SEL_B = 1'b1;
  localparam int   MAX_REPORTS = 10;
  localparam int   RAND_ITEMS = 16;   // item budget of the random test

  // one expected product coefficient
  typedef struct packed {
    coef_t coef;
    logic  is_last;
    logic  drop;
  } prod_item_t;

  logic  clk = 1'b0;
  logic  rst_n = 1'b0;
  logic  in_tvalid = 1'b0;
  logic  in_tready;
  coef_t in_tdata = '0;
  logic  in_tuser = 1'b0;
  logic  in_tlast = 1'b0;
  logic  out_tvalid;
  logic  out_tready = 1'b0;
  coef_t out_tdata;
  logic  out_tuser;
  logic  out_tlast;

  // model state: index 0 is A, index 1 is B
  coef_t opnd_store [2][COEF_SLOTS];
  int    load_idx [2];
  int    opnd_degree [2];
  logic  dropped;

  prod_item_t pending_products [$];
  int         mismatch_count = 0;

  // idling controls
  bit sender_gaps = 1'b1;
  bit sink_gaps = 1'b1;
  int sink_hold = 0;   // cycles the receiver still has to hold off

  polynomial_multiply dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Model: store one accepted coefficient, and when it ends B, queue every
  // coefficient of A*B. Sums wrap at 32 bits.
  // --------------------------------------------------------------------------
  task automatic absorb_coefficient(input logic to_b, input coef_t value,
                                    input logic mark_last);
    int s;
    int n_out;
    coef_t acc [PROD_SLOTS];
    prod_item_t r;
    s = to_b ? 1 : 0;
    if (load_idx[s] <= MAX_DEGREE) begin
      opnd_store[s][load_idx[s]] = value;
      load_idx[s]++;
    end else begin
      dropped = 1'b1;   // past the top slot, index stays saturated
    end
    if (mark_last) begin
      opnd_degree[s] = load_idx[s] - 1;
      load_idx[s] = 0;
    end
    if (to_b != SEL_B || !mark_last) return;

    // A mid-reload is fine: old degree, whatever the store holds right now
    foreach (acc[k]) acc[k] = '0;
    for (int i = 0; i <= opnd_degree[0]; i++)
      for (int j = 0; j <= opnd_degree[1]; j++)
        acc[i + j] = acc[i + j] + opnd_store[0][i] * opnd_store[1][j];
    n_out = opnd_degree[0] + opnd_degree[1] + 1;
    for (int k = 0; k < n_out; k++) begin
      r.coef = acc[k];
      r.is_last = (k == n_out - 1);
      r.drop = dropped;
      pending_products.push_back(r);
    end
    dropped = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Driver side. Valid stays high between back-to-back items; it only drops
  // on a random gap or a pause.
  // --------------------------------------------------------------------------
  task automatic send_coef(input logic to_b, input coef_t value, input logic mark_last);
    @(negedge clk);
    if (sender_gaps) begin
      while ($urandom_range(99) < 29) begin
        in_tvalid <= 1'b0;
        @(negedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tuser  <= to_b;
    in_tdata  <= value;
    in_tlast  <= mark_last;
    do @(posedge clk); while (!in_tready);
    absorb_coefficient(to_b, value, mark_last);
  endtask

  // sender goes quiet until every expected product coefficient is back
  task automatic pause_until_drained();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_products.size() != 0) @(posedge clk);
  endtask

  // mix of extremes, small signed values and full-range noise
  function automatic coef_t rand_coef();
    case ($urandom_range(5))
      0: case ($urandom_range(3))
           0: return 32'h0000_0000;
           1: return 32'h7FFF_FFFF;
           2: return 32'h8000_0000;
           default: return 32'hFFFF_FFFF;
         endcase
      1: return coef_t'($urandom_range(16)) - coef_t'(8);
      default: return coef_t'($urandom);
    endcase
  endfunction

  // mostly short operands, now and then a full or overfull one
  function automatic int rand_len();
    int r;
    r = $urandom_range(99);
    if (r < 70) return $urandom_range(6, 1);
    if (r < 90) return $urandom_range(20, 7);
    if (r < 97) return COEF_SLOTS;
    return $urandom_range(COEF_SLOTS + 3, COEF_SLOTS + 1);
  endfunction

  // trims an operand length to what is left of the item budget, at least one
  function automatic int fit_len(input int n, input int left);
    if (left < 1) return 1;
    return (n > left) ? left : n;
  endfunction

  task automatic load_poly(input logic to_b, input int n);
    for (int k = 0; k < n; k++) send_coef(to_b, rand_coef(), k == n - 1);
  endtask

  // --------------------------------------------------------------------------
  // Receiver: random stalls, or a long counted hold-off when asked
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (sink_hold > 0) begin
      out_tready <= 1'b0;
      sink_hold = sink_hold - 1;
    end else begin
      out_tready <= !(sink_gaps && ($urandom_range(99) < 29));
    end
  end

  task automatic note_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) $display("[%0t] MISMATCH %s", $realtime, what);
  endtask

  // each accepted result against the oldest expected one
  always @(posedge clk) begin : check_products
    prod_item_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_products.size() == 0) begin
        note_mismatch($sformatf("unexpected item coef=%h last=%b drop=%b",
                                out_tdata, out_tlast, out_tuser));
      end else begin
        want = pending_products.pop_front();
        if (out_tdata !== want.coef || out_tlast !== want.is_last
            || out_tuser !== want.drop) begin
          note_mismatch($sformatf("exp coef=%h last=%b drop=%b, got coef=%h last=%b drop=%b",
                                  want.coef, want.is_last, want.drop,
                                  out_tdata, out_tlast, out_tuser));
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // A was never loaded: it is the zero polynomial of degree 0
  task automatic test_unloaded_a();
    send_coef(SEL_B, 32'd5, 1'b0);
    send_coef(SEL_B, 32'hFFFF_FFFD, 1'b1);
    pause_until_drained();
  endtask

  // (1 + 2x)(3 + 4x + 5x^2)
  task automatic test_small_product();
    send_coef(SEL_A, 32'd1, 1'b0);
    send_coef(SEL_A, 32'd2, 1'b1);
    send_coef(SEL_B, 32'd3, 1'b0);
    send_coef(SEL_B, 32'd4, 1'b0);
    send_coef(SEL_B, 32'd5, 1'b1);
    pause_until_drained();
  endtask

  // most positive / most negative / -1: products and sums wrap
  task automatic test_extreme_values();
    send_coef(SEL_A, 32'h7FFF_FFFF, 1'b0);
    send_coef(SEL_A, 32'h8000_0000, 1'b1);
    send_coef(SEL_B, 32'hFFFF_FFFF, 1'b0);
    send_coef(SEL_B, 32'h8000_0000, 1'b1);
    pause_until_drained();
  endtask

  // B completes while A is half reloaded: old degree, new low entries
  task automatic test_partial_reload();
    send_coef(SEL_A, 32'd7, 1'b0);
    send_coef(SEL_A, 32'd8, 1'b0);
    send_coef(SEL_B, 32'd2, 1'b1);
    send_coef(SEL_A, 32'd9, 1'b1);
    send_coef(SEL_B, 32'hFFFF_FFFF, 1'b0);
    send_coef(SEL_B, 32'd1, 1'b1);
    pause_until_drained();
  endtask

  // too many coefficients on A, then on B: each flagged on the next product,
  // then the flag clears; the overfull B gives the full 63-coefficient product.
  // This stretch runs with no idling on either side.
  task automatic test_overflow_drop();
    sender_gaps = 1'b0;
    sink_gaps = 1'b0;
    load_poly(SEL_A, COEF_SLOTS + 1);
    load_poly(SEL_B, 1);
    load_poly(SEL_B, COEF_SLOTS + 1);
    load_poly(SEL_B, 1);
    pause_until_drained();
    sender_gaps = 1'b1;
    sink_gaps = 1'b1;
  endtask

  // receiver holds off so the block backs up and stalls its input
  task automatic test_backpressure();
    @(posedge clk);
    sink_hold = 500;
    repeat (2) begin
      load_poly(SEL_A, 4);
      load_poly(SEL_B, 5);
    end
    pause_until_drained();
  endtask

  // mostly well-formed A/B pairs with random content, some stray items
  task automatic test_random_products();
    int sent;
    int n;
    sent = 0;
    while (sent < RAND_ITEMS) begin
      if ($urandom_range(99) < 82) begin
        if ($urandom_range(99) < 80) begin
          n = fit_len(rand_len(), RAND_ITEMS - sent);
          load_poly(SEL_A, n);
          sent += n;
        end
        n = fit_len(rand_len(), RAND_ITEMS - sent);
        load_poly(SEL_B, n);
        sent += n;
      end else begin
        n = $urandom_range(4, 1);
        repeat (n) send_coef(1'($urandom_range(1)), rand_coef(), $urandom_range(99) < 30);
        sent += n;
      end
      if ($urandom_range(99) < 10) pause_until_drained();
    end
    pause_until_drained();
  endtask

  initial begin
    foreach (opnd_store[s, k]) opnd_store[s][k] = '0;
    load_idx = '{0, 0};
    opnd_degree = '{0, 0};
    dropped = 1'b0;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_unloaded_a();
    test_small_product();
    test_extreme_values();
    test_partial_reload();
    test_overflow_drop();
    test_backpressure();
    test_random_products();

    // let any stray late item show up
    repeat (200) @(posedge clk);
    if (mismatch_count == 0 && pending_products.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // hang guard, far above the slowest correct run
  initial begin
    #100_000_000;
    $display("status: fail");
    $finish;
  end

endmodule

// File: polynomial_multiply.f
+incdir+sv
sv/pm_pkg.sv
sv/pm_front.sv
sv/pm_queue.sv
sv/pm_back.sv
sv/polynomial_multiply.sv
tb/tb_polynomial_multiply.sv
